>>> hdl/rbsc_pkg.sv
`timescale 1ns / 1ps
// shared widths, constants and pipeline word types for the brightness scaler
package rbsc_pkg;

    localparam int CHAN_W             = 8;
    localparam int FACTOR_W           = 12;
    localparam int PROD_W             = CHAN_W + FACTOR_W;
    localparam int NUM_W              = 2 * CHAN_W;
    localparam int NUM_CH             = 3;
    localparam int STEP_BITS          = 2;
    localparam int DIV_STAGES         = CHAN_W / STEP_BITS;
    localparam int FRAC_BITS_DEFAULT  = 4;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(16);
    localparam logic [CHAN_W-1:0]   CHAN_MAX     = {CHAN_W{1'b1}};

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef struct packed {
        logic [NUM_W-1:0]  rem;
        logic [CHAN_W-1:0] quo;
        logic [CHAN_W-1:0] plain;
    } chan_t;

    typedef struct packed {
        chan_t [NUM_CH-1:0] ch;
        logic [CHAN_W-1:0]  peak;
        logic               clamp;
        logic               last;
    } word_t;

endpackage

>>> hdl/rbsc_front.sv
`timescale 1ns / 1ps
// front pipeline: channel products, peak detection, clamp decision and divide setup
module rbsc_front #(
    parameter int FACTOR_FRAC_BITS = rbsc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [rbsc_pkg::CHAN_W-1:0]    red,
    input  logic [rbsc_pkg::CHAN_W-1:0]    green,
    input  logic [rbsc_pkg::CHAN_W-1:0]    blue,
    input  logic                           last,
    input  logic [rbsc_pkg::FACTOR_W-1:0]  factor,
    output logic                           out_valid,
    input  logic                           out_ready,
    output rbsc_pkg::word_t                out_word
);

    localparam int CHAN_W = rbsc_pkg::CHAN_W;
    localparam int PROD_W = rbsc_pkg::PROD_W;
    localparam int NUM_W  = rbsc_pkg::NUM_W;
    localparam int NUM_CH = rbsc_pkg::NUM_CH;
    localparam logic [PROD_W-1:0] LIMIT = PROD_W'(rbsc_pkg::CHAN_MAX) << FACTOR_FRAC_BITS;

    logic [CHAN_W-1:0] chan_in [NUM_CH];
    logic [CHAN_W-1:0] peak_in;

    logic              a_valid_reg;
    logic [CHAN_W-1:0] a_chan_reg [NUM_CH];
    logic [PROD_W-1:0] a_prod_reg [NUM_CH];
    logic [PROD_W-1:0] a_peak_prod_reg;
    logic [CHAN_W-1:0] a_peak_reg;
    logic              a_last_reg;
    logic              a_ready;

    logic              b_valid_reg;
    rbsc_pkg::word_t   b_word_reg;
    rbsc_pkg::word_t   b_word_next;
    logic              b_ready;

    assign chan_in[rbsc_pkg::CH_RED]   = red;
    assign chan_in[rbsc_pkg::CH_GREEN] = green;
    assign chan_in[rbsc_pkg::CH_BLUE]  = blue;

    always_comb
    begin
        peak_in = red;
        if (green > peak_in)
        begin
            peak_in = green;
        end
        if (blue > peak_in)
        begin
            peak_in = blue;
        end
    end

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // stage a: multiply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                a_chan_reg[c] <= chan_in[c];
                a_prod_reg[c] <= PROD_W'(chan_in[c]) * PROD_W'(factor);
            end
            a_peak_prod_reg <= PROD_W'(peak_in) * PROD_W'(factor);
            a_peak_reg      <= peak_in;
            a_last_reg      <= last;
        end
    end

    // stage b: clamp decision and numerator setup
    always_comb
    begin
        b_word_next.peak  = a_peak_reg;
        b_word_next.clamp = a_peak_prod_reg > LIMIT;
        b_word_next.last  = a_last_reg;
        for (int c = 0; c < NUM_CH; c++)
        begin
            b_word_next.ch[c].rem   = {a_chan_reg[c], {CHAN_W{1'b0}}} - NUM_W'(a_chan_reg[c]);
            b_word_next.ch[c].quo   = '0;
            b_word_next.ch[c].plain = a_prod_reg[c][FACTOR_FRAC_BITS +: CHAN_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_word_reg <= b_word_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_word  = b_word_reg;

endmodule

>>> hdl/rbsc_div_step.sv
`timescale 1ns / 1ps
// one divider stage: resolves STEP_BITS quotient bits of each channel and registers the word
module rbsc_div_step #(
    parameter int QUO_HI = rbsc_pkg::CHAN_W - 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rbsc_pkg::word_t in_word,
    output logic            out_valid,
    input  logic            out_ready,
    output rbsc_pkg::word_t out_word
);

    localparam int NUM_W     = rbsc_pkg::NUM_W;
    localparam int NUM_CH    = rbsc_pkg::NUM_CH;
    localparam int STEP_BITS = rbsc_pkg::STEP_BITS;

    logic            valid_reg;
    rbsc_pkg::word_t word_reg;
    rbsc_pkg::word_t word_next;
    logic            ready;

    always_comb
    begin
        word_next = in_word;
        for (int c = 0; c < NUM_CH; c++)
        begin
            for (int k = 0; k < STEP_BITS; k++)
            begin
                if (word_next.ch[c].rem >= (NUM_W'(in_word.peak) << (QUO_HI - k)))
                begin
                    word_next.ch[c].rem = word_next.ch[c].rem
                                          - (NUM_W'(in_word.peak) << (QUO_HI - k));
                    word_next.ch[c].quo[QUO_HI - k] = 1'b1;
                end
            end
        end
    end

    assign ready    = !valid_reg || out_ready;
    assign in_ready = ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> hdl/rgb_brightness_scale_clamp_top.sv
`timescale 1ns / 1ps
// RGB brightness scaler with hue-preserving clamp. Takes one pixel per clock
// while the output is not stalled and returns one result per pixel, fully
// pipelined over six register stages (channel multiply, clamp decision and
// numerator setup, then four divider stages that each resolve two quotient
// bits). Each channel is multiplied by the factor written on the cfg port
// (FACTOR_FRAC_BITS fraction bits, reset 1.0); if the brightest scaled
// channel exceeds 255 all three become channel * 255 / brightest channel,
// truncated, and was_clamped is set. Write the factor only while the
// pipeline is empty; cfg_ready is always high.
module rgb_brightness_scale_clamp_top #(
    parameter int FACTOR_FRAC_BITS = rbsc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rbsc_pkg::FACTOR_W-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [rbsc_pkg::CHAN_W-1:0]    red_in,
    input  logic [rbsc_pkg::CHAN_W-1:0]    green_in,
    input  logic [rbsc_pkg::CHAN_W-1:0]    blue_in,
    input  logic                           last_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rbsc_pkg::CHAN_W-1:0]    red_out,
    output logic [rbsc_pkg::CHAN_W-1:0]    green_out,
    output logic [rbsc_pkg::CHAN_W-1:0]    blue_out,
    output logic                           was_clamped,
    output logic                           last_out
);

    localparam int DIV_STAGES = rbsc_pkg::DIV_STAGES;

    logic [rbsc_pkg::FACTOR_W-1:0] factor_reg;

    logic            stg_valid [DIV_STAGES+1];
    logic            stg_ready [DIV_STAGES+1];
    rbsc_pkg::word_t stg_word  [DIV_STAGES+1];
    rbsc_pkg::word_t final_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= rbsc_pkg::FACTOR_RESET;
        end
        else if (cfg_valid)
        begin
            factor_reg <= cfg_data;
        end
    end

    rbsc_front #(
        .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red       (red_in),
        .green     (green_in),
        .blue      (blue_in),
        .last      (last_in),
        .factor    (factor_reg),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_word  (stg_word[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        rbsc_div_step #(
            .QUO_HI (rbsc_pkg::CHAN_W - 1 - g * rbsc_pkg::STEP_BITS)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_word   (stg_word[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_word  (stg_word[g+1])
        );
    end

    assign stg_ready[DIV_STAGES] = out_ready;
    assign final_word            = stg_word[DIV_STAGES];

    assign out_valid   = stg_valid[DIV_STAGES];
    assign red_out     = final_word.clamp ? final_word.ch[rbsc_pkg::CH_RED].quo
                                          : final_word.ch[rbsc_pkg::CH_RED].plain;
    assign green_out   = final_word.clamp ? final_word.ch[rbsc_pkg::CH_GREEN].quo
                                          : final_word.ch[rbsc_pkg::CH_GREEN].plain;
    assign blue_out    = final_word.clamp ? final_word.ch[rbsc_pkg::CH_BLUE].quo
                                          : final_word.ch[rbsc_pkg::CH_BLUE].plain;
    assign was_clamped = final_word.clamp;
    assign last_out    = final_word.last;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the rgb brightness scaler with hue-preserving clamp
module testbench;

    localparam int CHAN_W        = rbsc_pkg::CHAN_W;
    localparam int FACTOR_W      = rbsc_pkg::FACTOR_W;
    localparam int FRAC          = rbsc_pkg::FRAC_BITS_DEFAULT;
    localparam int CLAMP_LIMIT   = 255 << FRAC;
    localparam int DRAIN_CYCLES  = 16;
    localparam int IDLE_LIMIT    = 4000;
    localparam int LONG_HOLD     = 200;
    localparam int HOLD_AT_SHADE = 500;
    localparam int PHASE_PIXELS  = 150;

    localparam int RDY_ALWAYS   = 0;
    localparam int RDY_COIN     = 1;
    localparam int RDY_MOSTLY   = 2;
    localparam int RDY_PERIODIC = 3;

    typedef struct {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic              last;
    } pixel_t;

    typedef struct {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic              clamped;
        logic              last;
    } shade_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [FACTOR_W-1:0] cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [CHAN_W-1:0]   red_in = '0;
    logic [CHAN_W-1:0]   green_in = '0;
    logic [CHAN_W-1:0]   blue_in = '0;
    logic                last_in = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [CHAN_W-1:0]   red_out;
    logic [CHAN_W-1:0]   green_out;
    logic [CHAN_W-1:0]   blue_out;
    logic                was_clamped;
    logic                last_out;

    pixel_t              pixel_q[$];
    shade_t              shade_q[$];
    logic [FACTOR_W-1:0] factor = rbsc_pkg::FACTOR_RESET;
    logic                in_took = 1'b0;
    int                  pixels_queued = 0;
    int                  pixels_taken = 0;
    int                  shades_seen = 0;
    int                  clamps_seen = 0;
    int                  settings_used = 1;
    int                  errors = 0;
    int                  idle_cycles = 0;

    int                  burst_left = 0;
    int                  gap_left = 0;
    int                  hold_left = 0;
    bit                  held_long = 1'b0;
    int                  ready_mode = RDY_ALWAYS;
    int                  mode_left = 0;
    int                  tick = 0;

    rgb_brightness_scale_clamp_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .last_in     (last_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .was_clamped (was_clamped),
        .last_out    (last_out)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic shade_t scale_pixel(pixel_t p, logic [FACTOR_W-1:0] f);
        shade_t s;
        int     pr;
        int     pg;
        int     pb;
        int     peak;
        pr = int'(p.r) * int'(f);
        pg = int'(p.g) * int'(f);
        pb = int'(p.b) * int'(f);
        peak = pr;
        if (pg > peak)
            peak = pg;
        if (pb > peak)
            peak = pb;
        if (peak > CLAMP_LIMIT)
        begin
            s.r = CHAN_W'((pr * 255) / peak);
            s.g = CHAN_W'((pg * 255) / peak);
            s.b = CHAN_W'((pb * 255) / peak);
            s.clamped = 1'b1;
        end
        else
        begin
            s.r = CHAN_W'(pr >> FRAC);
            s.g = CHAN_W'(pg >> FRAC);
            s.b = CHAN_W'(pb >> FRAC);
            s.clamped = 1'b0;
        end
        s.last = p.last;
        return s;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // monitor: records accepted words, predicts and checks results, watchdog
    always @(posedge clk)
    begin
        shade_t want;
        if (rst_n)
        begin
            in_took <= in_valid && in_ready;
            if (cfg_valid && cfg_ready)
                factor <= cfg_data;
            if (in_valid && in_ready)
            begin
                shade_q.push_back(scale_pixel('{red_in, green_in, blue_in, last_in}, factor));
                pixels_taken++;
            end
            if (out_valid && out_ready)
            begin
                shades_seen++;
                if (was_clamped)
                    clamps_seen++;
                if (shade_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result word with nothing expected", $time);
                end
                else
                begin
                    want = shade_q.pop_front();
                    check_field("red_out", int'(want.r), int'(red_out));
                    check_field("green_out", int'(want.g), int'(green_out));
                    check_field("blue_out", int'(want.b), int'(blue_out));
                    check_field("was_clamped", int'(want.clamped), int'(was_clamped));
                    check_field("last_out", int'(want.last), int'(last_out));
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, no word moved for %0d cycles", $time, idle_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // driver: bursts of pixels with random gaps
    always @(negedge clk)
    begin
        pixel_t p;
        if (rst_n && (!in_valid || in_took))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pixel_q.size() > 0)
            begin
                p = pixel_q.pop_front();
                red_in   <= p.r;
                green_in <= p.g;
                blue_in  <= p.b;
                last_in  <= p.last;
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: stall pattern plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!held_long && shades_seen >= HOLD_AT_SHADE)
        begin
            held_long = 1'b1;
            hold_left = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(RDY_ALWAYS, RDY_PERIODIC);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            tick++;
            case (ready_mode)
                RDY_ALWAYS:   out_ready <= 1'b1;
                RDY_COIN:     out_ready <= 1'($urandom_range(0, 1));
                RDY_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
                default:      out_ready <= ((tick % 5) < 3);
            endcase
        end
    end

    task automatic queue_pixel(int r, int g, int b, int last);
        pixel_q.push_back('{CHAN_W'(r), CHAN_W'(g), CHAN_W'(b), 1'(last)});
        pixels_queued++;
    endtask

    task automatic drain();
        while (pixels_taken != pixels_queued || shade_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_factor(int value);
        drain();
        cfg_data  <= FACTOR_W'(value);
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic int pick_chan(int f, int kind);
        int edge_val;
        edge_val = (f == 0) ? 255 : CLAMP_LIMIT / f;
        case (kind)
            0, 1, 2, 3, 4: return $urandom_range(0, 255);
            5:             return ($urandom_range(0, 1) == 0) ? 0 : 255;
            6, 7:          return $urandom_range(0, (edge_val > 255) ? 255 : edge_val);
            default:
            begin
                if (edge_val >= 255)
                    return $urandom_range(250, 255);
                return edge_val + $urandom_range(0, 1);
            end
        endcase
    endfunction

    task automatic queue_random(int f, int count);
        int kind;
        repeat (count)
        begin
            kind = $urandom_range(0, 9);
            queue_pixel(pick_chan(f, kind), pick_chan(f, kind), pick_chan(f, kind),
                        ($urandom_range(0, 15) == 0));
        end
    endtask

    initial
    begin
        int factors[10];
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // unity factor: extremes and single channels
        queue_pixel(0, 0, 0, 0);
        queue_pixel(255, 255, 255, 1);
        queue_pixel(255, 0, 0, 0);
        queue_pixel(0, 255, 0, 1);
        queue_pixel(0, 0, 255, 0);
        queue_pixel(1, 2, 3, 0);

        // just at and just past 255.0
        write_factor(17);
        queue_pixel(240, 240, 240, 0);
        queue_pixel(241, 0, 0, 1);
        queue_pixel(241, 120, 60, 0);
        queue_pixel(255, 128, 1, 0);

        // zero factor
        write_factor(0);
        queue_pixel(255, 255, 255, 1);
        queue_pixel(17, 34, 51, 0);

        // largest factor
        write_factor(4095);
        queue_pixel(255, 255, 255, 0);
        queue_pixel(1, 0, 0, 1);
        queue_pixel(1, 1, 0, 0);
        queue_pixel(0, 0, 0, 0);
        queue_pixel(255, 1, 128, 1);

        write_factor(1);
        queue_pixel(255, 255, 255, 0);
        queue_pixel(15, 16, 17, 1);

        factors = '{32, 8, 4095, 24, 0, 1, 16, 0, 0, 0};
        factors[7] = $urandom_range(0, 4095);
        factors[8] = $urandom_range(16, 64);
        factors[9] = $urandom_range(2, 15);
        foreach (factors[i])
        begin
            write_factor(factors[i]);
            queue_random(factors[i], PHASE_PIXELS);
        end

        drain();
        $display("covered %0d pixels (%0d clamped) across %0d factor settings",
                 shades_seen, clamps_seen, settings_used);
        $display("receiver held off for %0d cycles once, %0d mismatches", LONG_HOLD, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
hdl/rbsc_pkg.sv
hdl/rbsc_front.sv
hdl/rbsc_div_step.sv
hdl/rgb_brightness_scale_clamp_top.sv
tb/sv/testbench.sv
